@@ sv/evhc_pkg.sv @@
// Package: shared types, constants and functions for the volume header checker.
`timescale 1ns / 1ps

package evhc_pkg;

	typedef logic [9:0] pos_t;

	localparam pos_t SIG_LO    = 10'd64;
	localparam pos_t VER_LO    = 10'd68;
	localparam pos_t REQ_LO    = 10'd70;
	localparam pos_t KCRC_LO   = 10'd72;
	localparam pos_t KCRC_HI   = 10'd76;
	localparam pos_t SIZE_LO   = 10'd92;
	localparam pos_t WORD_LO   = 10'd124;
	localparam pos_t WORD_HI   = 10'd132;
	localparam pos_t HCRC_END  = 10'd252;
	localparam pos_t KEY_LO    = 10'd256;
	localparam pos_t HDR_BYTES = 10'd512;
	localparam pos_t COUNT_SAT = 10'd513;

	localparam logic [31:0] CRC_POLY = 32'hedb88320;
	localparam logic [31:0] CRC_INIT = 32'hffffffff;

	localparam logic [15:0] VER_MIN  = 16'd3;
	localparam logic [15:0] VER_HCRC = 16'd4;
	localparam logic [15:0] VER_MAX  = 16'd5;

	localparam logic [31:0] SECTOR_512  = 32'd512;
	localparam logic [31:0] SECTOR_1K   = 32'd1024;
	localparam logic [31:0] SECTOR_2K   = 32'd2048;
	localparam logic [31:0] SECTOR_4K   = 32'd4096;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SIZE      = 3'd1,
		ST_SIGNATURE = 3'd2,
		ST_VERSION   = 3'd3,
		ST_HDR_CRC   = 3'd4,
		ST_KEY_CRC   = 3'd5,
		ST_SECTOR    = 3'd6,
		ST_AREA      = 3'd7
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} hdr_item_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] format_version;
		logic [15:0] required_version;
		logic [63:0] hidden_volume_size;
		logic [63:0] volume_data_size;
		logic [63:0] area_length;
		logic [63:0] area_start;
		logic [31:0] volume_flags;
		logic [31:0] sector_bytes;
	} report_t;

	typedef struct packed {
		pos_t        byte_count;
		logic        sig_ok;
		logic [31:0] hdr_crc;
		logic [31:0] key_crc;
		logic [31:0] stored_hdr_crc;
		logic [31:0] stored_key_crc;
		logic [15:0] hdr_ver;
		logic [15:0] req_ver;
		logic [63:0] hidden_size;
		logic [63:0] data_size;
		logic [63:0] area_off;
		logic [63:0] area_len;
		logic [31:0] flags;
		logic [31:0] sector;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		byte_count:     '0,
		sig_ok:         1'b1,
		hdr_crc:        CRC_INIT,
		key_crc:        CRC_INIT,
		stored_hdr_crc: '0,
		stored_key_crc: '0,
		hdr_ver:        '0,
		req_ver:        '0,
		hidden_size:    '0,
		data_size:      '0,
		area_off:       '0,
		area_len:       '0,
		flags:          '0,
		sector:         '0
	};

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

	function automatic logic [7:0] sig_byte(input logic [1:0] idx);
		logic [7:0] s;
		unique case (idx)
			2'd0: s = 8'h56;
			2'd1: s = 8'h45;
			2'd2: s = 8'h52;
			default: s = 8'h41;
		endcase
		return s;
	endfunction

endpackage

@@ sv/evhc_stream_if.sv @@
// Valid/ready stream interface carrying one payload per transaction.
`timescale 1ns / 1ps

interface evhc_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ sv/encrypted_volume_header_checker.sv @@
// Top level: volume header checker, one header byte per transaction.
// Throughput: one byte per cycle while the report side keeps up.
// The report is registered into the output stage, or into the skid stage while the output is held.
// A report waiting on a stalled output does not block input bytes; a second
// pending report fills the skid stage and only then is input held off.
// Reset (arst_n low) clears the parser to a fresh header and empties the output and skid stages.
`timescale 1ns / 1ps

module encrypted_volume_header_checker (
	input  logic          clk,
	input  logic          arst_n,
	evhc_stream_if.sink   hdr,
	evhc_stream_if.source report
);

	logic                   accept;
	logic                   can_push;
	evhc_pkg::parse_state_t state_n;
	evhc_pkg::hdr_item_t    item;

	assign item      = hdr.payload;
	assign hdr.ready = can_push;
	assign accept    = hdr.valid && can_push;

	evhc_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (item.data_byte),
		.last_byte (item.last_byte),
		.state_n   (state_n)
	);

	evhc_check u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept && item.last_byte),
		.state_n  (state_n),
		.can_push (can_push),
		.report   (report)
	);

endmodule

@@ sv/evhc_parse.sv @@
// Byte parser: counter, signature check, field capture and both CRC accumulators.
`timescale 1ns / 1ps

module evhc_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	output evhc_pkg::parse_state_t state_n
);

	evhc_pkg::parse_state_t state_q;
	evhc_pkg::pos_t         pos;
	evhc_pkg::pos_t         off_size;
	evhc_pkg::pos_t         off_word;

	always_comb begin
		state_n  = state_q;
		pos      = state_q.byte_count;
		off_size = pos - evhc_pkg::SIZE_LO;
		off_word = pos - evhc_pkg::WORD_LO;
		if (pos < evhc_pkg::HDR_BYTES) begin
			if (pos >= evhc_pkg::SIG_LO && pos < evhc_pkg::VER_LO &&
			    data_byte != evhc_pkg::sig_byte(pos[1:0])) begin
				state_n.sig_ok = 1'b0;
			end
			if (pos >= evhc_pkg::SIG_LO && pos < evhc_pkg::HCRC_END) begin
				state_n.hdr_crc = evhc_pkg::crc_byte(state_q.hdr_crc, data_byte);
			end
			if (pos >= evhc_pkg::KEY_LO) begin
				state_n.key_crc = evhc_pkg::crc_byte(state_q.key_crc, data_byte);
			end
			if (pos >= evhc_pkg::VER_LO && pos < evhc_pkg::REQ_LO) begin
				state_n.hdr_ver = {state_q.hdr_ver[7:0], data_byte};
			end else if (pos >= evhc_pkg::REQ_LO && pos < evhc_pkg::KCRC_LO) begin
				state_n.req_ver = {state_q.req_ver[7:0], data_byte};
			end else if (pos >= evhc_pkg::KCRC_LO && pos < evhc_pkg::KCRC_HI) begin
				state_n.stored_key_crc = {state_q.stored_key_crc[23:0], data_byte};
			end else if (pos >= evhc_pkg::SIZE_LO && pos < evhc_pkg::WORD_LO) begin
				case (off_size[4:3])
					2'd0: state_n.hidden_size = {state_q.hidden_size[55:0], data_byte};
					2'd1: state_n.data_size   = {state_q.data_size[55:0], data_byte};
					2'd2: state_n.area_off    = {state_q.area_off[55:0], data_byte};
					default: state_n.area_len = {state_q.area_len[55:0], data_byte};
				endcase
			end else if (pos >= evhc_pkg::WORD_LO && pos < evhc_pkg::WORD_HI) begin
				if (off_word[2]) begin
					state_n.sector = {state_q.sector[23:0], data_byte};
				end else begin
					state_n.flags = {state_q.flags[23:0], data_byte};
				end
			end else if (pos >= evhc_pkg::HCRC_END && pos < evhc_pkg::KEY_LO) begin
				state_n.stored_hdr_crc = {state_q.stored_hdr_crc[23:0], data_byte};
			end
		end
		if (pos < evhc_pkg::COUNT_SAT) begin
			state_n.byte_count = pos + 10'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= evhc_pkg::STATE_RESET;
		end else if (accept) begin
			state_q <= last_byte ? evhc_pkg::STATE_RESET : state_n;
		end
	end

endmodule

@@ sv/evhc_check.sv @@
// Final header checks and the result register with its skid stage.
`timescale 1ns / 1ps

module evhc_check (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  evhc_pkg::parse_state_t state_n,
	output logic                   can_push,
	evhc_stream_if.source          report
);

	evhc_pkg::report_t res;
	evhc_pkg::report_t out_q;
	evhc_pkg::report_t skid_q;
	logic              out_vld_q;
	logic              skid_vld_q;
	logic              pop;
	logic [31:0]       sector;
	logic              sector_ok;
	evhc_pkg::status_t status;

	always_comb begin
		sector = (state_n.hdr_ver < evhc_pkg::VER_MAX) ? evhc_pkg::SECTOR_512 : state_n.sector;
		sector_ok = sector == evhc_pkg::SECTOR_512 || sector == evhc_pkg::SECTOR_1K ||
		            sector == evhc_pkg::SECTOR_2K || sector == evhc_pkg::SECTOR_4K;
		if (state_n.byte_count != evhc_pkg::HDR_BYTES) begin
			status = evhc_pkg::ST_SIZE;
		end else if (!state_n.sig_ok) begin
			status = evhc_pkg::ST_SIGNATURE;
		end else if (state_n.hdr_ver < evhc_pkg::VER_MIN ||
		             state_n.hdr_ver > evhc_pkg::VER_MAX) begin
			status = evhc_pkg::ST_VERSION;
		end else if (state_n.hdr_ver >= evhc_pkg::VER_HCRC &&
		             ~state_n.hdr_crc != state_n.stored_hdr_crc) begin
			status = evhc_pkg::ST_HDR_CRC;
		end else if (~state_n.key_crc != state_n.stored_key_crc) begin
			status = evhc_pkg::ST_KEY_CRC;
		end else if (!sector_ok) begin
			status = evhc_pkg::ST_SECTOR;
		end else if (state_n.area_len == 64'd0 || state_n.area_off > ~state_n.area_len) begin
			status = evhc_pkg::ST_AREA;
		end else begin
			status = evhc_pkg::ST_OK;
		end

		res = '0;
		res.status = status;
		if (status == evhc_pkg::ST_OK) begin
			res.format_version     = state_n.hdr_ver;
			res.required_version   = state_n.req_ver;
			res.hidden_volume_size = state_n.hidden_size;
			res.volume_data_size   = state_n.data_size;
			res.area_length        = state_n.area_len;
			res.area_start         = state_n.area_off;
			res.volume_flags       = state_n.flags;
			res.sector_bytes       = sector;
		end
	end

	assign pop            = out_vld_q && report.ready;
	assign can_push       = !skid_vld_q;
	assign report.valid   = out_vld_q;
	assign report.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (pop) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_vld_q || pop) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (!out_vld_q || pop) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

endmodule
